FILE: sv/lfa_pkg.sv
// Shared types and constants for the lowest-free identifier allocator.
// Field widths, request codes and status codes. Depends on nothing.
package lfa_pkg;

  localparam int REQ_W  = 1;
  localparam int ID_W   = 4;
  localparam int STAT_W = 2;

  typedef logic [REQ_W-1:0]  req_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [STAT_W-1:0] stat_t;

  localparam req_t REQ_ALLOC   = 1'b0;
  localparam req_t REQ_RELEASE = 1'b1;

  localparam stat_t STAT_OK   = 2'd0;
  localparam stat_t STAT_FULL = 2'd1;
  localparam stat_t STAT_BAD  = 2'd2;

endpackage

FILE: sv/lfa_if.sv
// Valid/ready channel interfaces for the allocator request and result words.
// Depends on lfa_pkg for the field types.
interface lfa_req_if;
  logic          valid;
  logic          ready;
  lfa_pkg::req_t req_type;
  lfa_pkg::id_t  release_id;

  modport source (output valid, output req_type, output release_id, input ready);
  modport sink   (input valid, input req_type, input release_id, output ready);
endinterface

interface lfa_rsp_if;
  logic           valid;
  logic           ready;
  lfa_pkg::id_t   granted_id;
  lfa_pkg::stat_t status;

  modport source (output valid, output granted_id, output status, input ready);
  modport sink   (input valid, input granted_id, input status, output ready);
endinterface

FILE: sv/lfa_enc.sv
// Lowest-free slot priority encoder over the busy bitmap.
// Purely combinational; no package dependency.
module lfa_enc #(
  parameter int SLOTS = 8,
  parameter int IDX_W = 3
) (
  input  logic [SLOTS-1:0] busy_map,
  output logic             found,
  output logic [IDX_W-1:0] idx
);

  logic [SLOTS-1:0] free_bits;
  logic [SLOTS-1:0] lowest;

  assign free_bits = ~busy_map;
  // isolate the lowest set bit
  assign lowest    = free_bits & (~free_bits + SLOTS'(1));
  assign found     = |free_bits;

  always_comb begin
    idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (lowest[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
  end

endmodule

FILE: sv/lowest_free_id_allocator.sv
// Top level of the lowest-free identifier allocator.
// Depends on lfa_pkg, lfa_req_if / lfa_rsp_if and lfa_enc.
//
// Usage:
//   in_ch carries request words: req_type selects allocate or release, and
//   release_id names the identifier to free (ignored on allocate).
//   out_ch carries one result word per request: granted_id (lowest free
//   identifier on a good allocate, else 0) and status (ok, full, bad id).
//   Identifiers run 1..SLOTS; a release of 0 or of an id above SLOTS reports
//   bad id and changes nothing. Granted ids are reported in 4 bits.
// Timing:
//   A request word lands in an input register at acceptance; when the result
//   register can take it, the priority encoder runs, the busy bitmap updates
//   and the result register loads and offers the word. One word per cycle
//   sustained while out_ch does not stall; the bitmap update and encoder lookup
//   complete in that single stage, so each request sees every earlier one.
// Reset and stalls:
//   Reset clears the bitmap (all identifiers free) and empties both stages.
//   While out_ch is stalled the result register holds, the input register
//   holds its word, and in_ch.ready drops once both are occupied.
module lowest_free_id_allocator #(
  parameter int SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  lfa_req_if.sink       in_ch,
  lfa_rsp_if.source     out_ch
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SUM_W = (IDX_W + 1 > lfa_pkg::ID_W) ? IDX_W + 1 : lfa_pkg::ID_W;

  // input stage
  logic          stg_valid_r;
  lfa_pkg::req_t stg_req_r;
  lfa_pkg::id_t  stg_id_r;

  // result stage
  logic           out_valid_r;
  lfa_pkg::id_t   out_gid_r, out_gid_nxt;
  lfa_pkg::stat_t out_stat_r, out_stat_nxt;

  logic [SLOTS-1:0] busy_map_r, busy_map_nxt;

  logic             found;
  logic [IDX_W-1:0] idx;
  logic [SUM_W-1:0] gid_sum;
  logic             id_ok;
  logic             advance;
  logic             in_fire;

  // advance the stage into the result register when it can take a word
  assign advance = stg_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !stg_valid_r || advance;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.granted_id = out_gid_r;
  assign out_ch.status     = out_stat_r;

  lfa_enc #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_enc (
    .busy_map (busy_map_r),
    .found    (found),
    .idx      (idx)
  );

  assign gid_sum = SUM_W'(idx) + SUM_W'(1);
  assign id_ok   = (stg_id_r != '0) && (int'(stg_id_r) <= SLOTS);

  always_comb begin
    busy_map_nxt = busy_map_r;
    out_gid_nxt  = '0;
    out_stat_nxt = lfa_pkg::STAT_OK;
    if (stg_req_r == lfa_pkg::REQ_ALLOC) begin
      if (found) begin
        busy_map_nxt = busy_map_r | (SLOTS'(1) << idx);
        out_gid_nxt  = gid_sum[lfa_pkg::ID_W-1:0];
      end else begin
        out_stat_nxt = lfa_pkg::STAT_FULL;
      end
    end else begin
      if (id_ok) begin
        // drop the busy bit of the named identifier
        for (int i = 0; i < SLOTS; i++) begin
          if (int'(stg_id_r) == i + 1) begin
            busy_map_nxt[i] = 1'b0;
          end
        end
      end else begin
        out_stat_nxt = lfa_pkg::STAT_BAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      busy_map_r  <= '0;
    end else begin
      if (in_ch.ready) begin
        stg_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        busy_map_r  <= busy_map_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_req_r <= in_ch.req_type;
      stg_id_r  <= in_ch.release_id;
    end
    if (advance) begin
      out_gid_r  <= out_gid_nxt;
      out_stat_r <= out_stat_nxt;
    end
  end

  // full is reported only when every slot is busy
  a_full_means_all_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && stg_req_r == lfa_pkg::REQ_ALLOC && !found) |-> (&busy_map_r))
    else $error("full reported with a free slot");

  // a good allocate marks exactly one more slot busy
  a_alloc_adds_one: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && stg_req_r == lfa_pkg::REQ_ALLOC && found)
      |=> ($countones(busy_map_r) == $countones($past(busy_map_r)) + 1))
    else $error("allocate did not add exactly one busy slot");

  // a release never marks a slot busy
  a_release_no_set: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && stg_req_r == lfa_pkg::REQ_RELEASE)
      |=> ((busy_map_r & ~$past(busy_map_r)) == '0))
    else $error("release set a busy bit");

  // only a good allocate carries a nonzero identifier
  a_gid_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r != lfa_pkg::STAT_OK) |-> (out_gid_r == '0))
    else $error("identifier granted with error status");

  // input back-pressure only when both stages hold words and output stalls
  a_ready_low_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (stg_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without cause");

endmodule
